[hdl/ptu_pkg.sv]
// Shared types, constants and tables of the particle table core.
package ptu_pkg;

    localparam int SLOTS        = 64;
    localparam int SINE_ENTRIES = 256;
    localparam int ADDR_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W        = $clog2(SLOTS + 1);
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
    localparam int DRAG_STEPS   = 12;
    localparam int DIV_STEPS    = 25;
    localparam int IN_W         = 168;
    localparam int OUT_W        = 128;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_DROP   = 2'd1;
    localparam logic [1:0] KIND_QUAD   = 2'd2;

    localparam logic       FUNC_INSERT = 1'b0;

    localparam logic [17:0] K_PULSE15 = 18'd156456;
    localparam logic [17:0] K_PULSE20 = 18'd208608;

    typedef logic [15:0] t_drag_tab [DRAG_STEPS];
    localparam t_drag_tab DRAG_TAB = '{
        16'd46341, 16'd55109, 16'd60097, 16'd62757, 16'd64132, 16'd64830,
        16'd65182, 16'd65359, 16'd65447, 16'd65492, 16'd65514, 16'd65525
    };

    typedef logic signed [15:0] t_sine_tab [SINE_ENTRIES];

    // Odd polynomial per quarter wave, Q1.15.
    function automatic t_sine_tab build_sine();
        t_sine_tab tab;
        longint t, q, r, x, x15, x2, inner, mid, v;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            t     = (longint'(i) * 65536) / SINE_ENTRIES;
            q     = (t >> 14) & 3;
            r     = t & 16'h3FFF;
            x     = ((q & 1) != 0) ? (16384 - r) : r;
            x15   = x * 2;
            x2    = (x15 * x15) >> 15;
            inner = 21167 - ((x2 * 2611) >> 15);
            mid   = 51472 - ((x2 * inner) >> 15);
            v     = (x15 * mid) >> 15;
            if (v > 32767) v = 32767;
            if (q >= 2) v = -v;
            tab[i] = 16'(v);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [19:0] vel_x;
        logic signed [19:0] vel_y;
        logic [15:0]        life;
        logic [23:0]        rec;
        logic [31:0]        color;
        logic [11:0]        size;
        logic               sparkle;
    } t_part;

    typedef struct packed {
        logic load_in;
        logic div_step;
        logic ins_wr;
        logic resp;
        logic drag_init;
        logic drag_step;
        logic rd_idx;
        logic rd_last;
        logic cnt_dec;
        logic copy_wr;
        logic upd_prod;
        logic upd_wr;
        logic idx_clr;
        logic q_mul1;
        logic q_mul2;
        logic q_mul3;
        logic q_out;
    } t_cmd;

    typedef struct packed {
        logic in_func;
        logic full;
        logic div_last;
        logic drag_last;
        logic idx_ge_cnt;
        logic cnt_zero;
        logic expired;
        logic idx_is_last;
        logic out_free;
    } t_stat;

    function automatic logic [23:0] sat24(logic signed [25:0] x);
        if (x > 26'sd8388607)       return 24'h7FFFFF;
        else if (x < -26'sd8388608) return 24'h800000;
        else                        return x[23:0];
    endfunction

endpackage

[hdl/ptu_ctrl.sv]
// Sequencer of the particle table core.
module ptu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ptu_pkg::t_stat  i_stat,
    output logic            o_in_ready,
    output ptu_pkg::t_cmd   o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DIV   = 12'b000000000010,
        S_INS   = 12'b000000000100,
        S_RESP  = 12'b000000001000,
        S_DRAG  = 12'b000000010000,
        S_UREAD = 12'b000000100000,
        S_UCHK  = 12'b000001000000,
        S_UCOPY = 12'b000010000000,
        S_UWR   = 12'b000100000000,
        S_QREAD = 12'b001000000000,
        S_Q1    = 12'b010000000000,
        S_Q2Q3  = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_q3, n_q3;
    logic   r_q4, n_q4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q3    <= 1'b0;
            r_q4    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_q3    <= n_q3;
            r_q4    <= n_q4;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_q3    = 1'b0;
        n_q4    = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_stat.in_func == ptu_pkg::FUNC_INSERT) begin
                        n_state = i_stat.full ? S_RESP : S_DIV;
                    end else begin
                        // restart the walk at slot 0
                        o_cmd.drag_init = 1'b1;
                        o_cmd.idx_clr   = 1'b1;
                        n_state = S_DRAG;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_INS;
            end
            S_INS: begin
                o_cmd.ins_wr = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DRAG: begin
                o_cmd.drag_step = 1'b1;
                if (i_stat.drag_last) n_state = S_UREAD;
            end
            S_UREAD: begin
                if (i_stat.idx_ge_cnt) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = i_stat.cnt_zero ? S_IDLE : S_QREAD;
                end else begin
                    o_cmd.rd_idx = 1'b1;
                    n_state = S_UCHK;
                end
            end
            S_UCHK: begin
                if (i_stat.expired) begin
                    if (i_stat.idx_is_last) begin
                        o_cmd.cnt_dec = 1'b1;
                        n_state = S_UREAD;
                    end else begin
                        o_cmd.rd_last = 1'b1;
                        n_state = S_UCOPY;
                    end
                end else begin
                    o_cmd.upd_prod = 1'b1;
                    n_state = S_UWR;
                end
            end
            S_UCOPY: begin
                o_cmd.copy_wr = 1'b1;
                o_cmd.cnt_dec = 1'b1;
                n_state = S_UREAD;
            end
            S_UWR: begin
                o_cmd.upd_wr = 1'b1;
                n_state = S_UREAD;
            end
            S_QREAD: begin
                o_cmd.rd_idx = 1'b1;
                n_state = S_Q1;
            end
            S_Q1: begin
                o_cmd.q_mul1 = 1'b1;
                n_state = S_Q2Q3;
            end
            S_Q2Q3: begin
                // walk the three remaining quad stages inside one state
                if (!r_q3 && !r_q4) begin
                    o_cmd.q_mul2 = 1'b1;
                    n_q3 = 1'b1;
                end else if (r_q3) begin
                    o_cmd.q_mul3 = 1'b1;
                    n_q4 = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.q_out = 1'b1;
                    n_state = i_stat.idx_is_last ? S_IDLE : S_QREAD;
                end else begin
                    n_q4 = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[hdl/ptu_dp.sv]
// Datapath of the particle table core: store, divider, multipliers, result register.
module ptu_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ptu_pkg::t_cmd                i_cmd,
    output ptu_pkg::t_stat               o_stat,
    input  logic                         i_func,
    input  logic [ptu_pkg::IN_W-1:0]     i_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_out_kind,
    output logic [ptu_pkg::OUT_W-1:0]    o_out_data,
    output logic                         o_out_last
);

    localparam int SB = ptu_pkg::SINE_BITS;

    ptu_pkg::t_part r_mem [ptu_pkg::SLOTS];
    ptu_pkg::t_part r_rd;
    ptu_pkg::t_part r_new;

    logic [ptu_pkg::CNT_W-1:0]  r_count;
    logic [ptu_pkg::CNT_W-1:0]  r_idx;
    logic [11:0]                r_step;
    logic                       r_drop;
    logic [16:0]                r_div_rem;
    logic [24:0]                r_div_q;
    logic [4:0]                 r_div_cnt;
    logic [16:0]                r_f;
    logic [3:0]                 r_k;
    logic signed [32:0]         r_mvx, r_mvy;
    logic signed [37:0]         r_dvx, r_dvy;
    logic [39:0]                r_ratio_raw;
    logic [34:0]                r_ph15, r_ph20;
    logic [24:0]                r_ar;
    logic [9:0]                 r_alpha;
    logic [16:0]                r_half;
    logic                       r_out_valid;
    logic [1:0]                 r_out_kind;
    logic [ptu_pkg::OUT_W-1:0]  r_out_data;
    logic                       r_out_last;

    logic [ptu_pkg::CNT_W-1:0]  cnt_m1;
    logic [16:0]                rem_sh;
    logic                       div_ge;
    logic [23:0]                rec;
    logic [15:0]                DRAG_TAB_K;
    logic [32:0]                f_prod;
    logic signed [32:0]         mvx_r, mvy_r;
    logic signed [37:0]         dvx_r, dvy_r;
    ptu_pkg::t_part             upd;
    logic [16:0]                ratio;
    logic [SB-1:0]              idx15, idx20;
    logic signed [16:0]         p_sum;
    logic signed [17:0]         g_sum;
    logic [15:0]                p_val, g_val;
    logic [40:0]                arp;
    logic [28:0]                sg;
    logic [7:0]                 alpha_c;
    logic signed [25:0]         hx;
    logic                       we;
    logic [ptu_pkg::ADDR_W-1:0] wa;
    ptu_pkg::t_part             wd;

    assign cnt_m1 = r_count - 1'b1;

    // status to the sequencer
    assign o_stat.in_func     = i_func;
    assign o_stat.full        = (r_count >= ptu_pkg::CNT_W'(ptu_pkg::SLOTS));
    assign o_stat.div_last    = (r_div_cnt == 5'(ptu_pkg::DIV_STEPS - 1));
    assign o_stat.drag_last   = (r_k == 4'(ptu_pkg::DRAG_STEPS - 1));
    assign o_stat.idx_ge_cnt  = (r_idx >= r_count);
    assign o_stat.cnt_zero    = (r_count == '0);
    assign o_stat.expired     = (r_rd.life <= {4'd0, r_step});
    assign o_stat.idx_is_last = (r_idx == cnt_m1);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    // restoring divide of 2^24 by life
    assign rem_sh = {r_div_rem[15:0], (r_div_cnt == '0)};
    assign div_ge = (rem_sh >= {1'b0, r_new.life});
    assign rec    = ((r_new.life == '0) || r_div_q[24]) ? 24'hFFFFFF : r_div_q[23:0];

    assign DRAG_TAB_K = ptu_pkg::DRAG_TAB[r_k];
    assign f_prod = r_f * DRAG_TAB_K + 33'd32768;

    // particle update
    assign mvx_r = (r_mvx + 33'sd2048) >>> 12;
    assign mvy_r = (r_mvy + 33'sd2048) >>> 12;
    assign dvx_r = (r_dvx + 38'sd32768) >>> 16;
    assign dvy_r = (r_dvy + 38'sd32768) >>> 16;

    always_comb begin
        upd       = r_rd;
        upd.life  = r_rd.life - {4'd0, r_step};
        upd.pos_x = ptu_pkg::sat24(26'(r_rd.pos_x) + 26'(mvx_r));
        upd.pos_y = ptu_pkg::sat24(26'(r_rd.pos_y) + 26'(mvy_r));
        upd.vel_x = dvx_r[19:0];
        upd.vel_y = dvy_r[19:0];
    end

    // quad stages
    assign ratio = (r_ratio_raw[39:8] > 32'd65536) ? 17'd65536 : r_ratio_raw[24:8];
    assign idx15 = r_ph15[31 -: SB];
    assign idx20 = r_ph20[31 -: SB];
    assign p_sum = 17'(ptu_pkg::SINE_TAB[idx15]) + 17'sd32768;
    assign g_sum = 18'(ptu_pkg::SINE_TAB[idx20]) + 18'sd39322;
    assign p_val = p_sum[16:1];
    assign g_val = g_sum[16:1];
    assign arp   = 41'(r_ar) * 41'(p_val);
    assign sg    = 29'(r_rd.size) * 29'(g_val);
    assign alpha_c = (r_alpha > 10'd255) ? 8'd255 : r_alpha[7:0];
    assign hx    = 26'(signed'({1'b0, r_half}));

    // single write port
    always_comb begin
        we = 1'b0;
        wa = r_idx[ptu_pkg::ADDR_W-1:0];
        wd = r_rd;
        if (i_cmd.ins_wr) begin
            we = 1'b1;
            wa = r_count[ptu_pkg::ADDR_W-1:0];
            wd = r_new;
            wd.rec = rec;
        end else if (i_cmd.copy_wr) begin
            we = 1'b1;
        end else if (i_cmd.upd_wr) begin
            we = 1'b1;
            wd = upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (i_cmd.rd_idx)  r_rd <= r_mem[r_idx[ptu_pkg::ADDR_W-1:0]];
        if (i_cmd.rd_last) r_rd <= r_mem[cnt_m1[ptu_pkg::ADDR_W-1:0]];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_step        <= i_data[11:0];
            r_new.pos_x   <= i_data[35:12];
            r_new.pos_y   <= i_data[59:36];
            r_new.vel_x   <= i_data[79:60];
            r_new.vel_y   <= i_data[99:80];
            r_new.life    <= i_data[115:100];
            r_new.rec     <= '0;
            r_new.color   <= i_data[147:116];
            r_new.size    <= i_data[159:148];
            r_new.sparkle <= i_data[160];
            r_drop        <= o_stat.full;
            r_div_rem     <= '0;
            r_div_q       <= '0;
            r_div_cnt     <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_rem <= div_ge ? (rem_sh - {1'b0, r_new.life}) : rem_sh;
            r_div_q   <= {r_div_q[23:0], div_ge};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.drag_init) begin
            r_f <= 17'd65536;
            r_k <= '0;
        end
        if (i_cmd.drag_step) begin
            if (r_step[4'd11 - r_k]) r_f <= f_prod[32:16];
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.upd_prod) begin
            r_mvx <= 33'(r_rd.vel_x) * 33'(signed'({1'b0, r_step}));
            r_mvy <= 33'(r_rd.vel_y) * 33'(signed'({1'b0, r_step}));
            r_dvx <= 38'(r_rd.vel_x) * 38'(signed'({1'b0, r_f}));
            r_dvy <= 38'(r_rd.vel_y) * 38'(signed'({1'b0, r_f}));
        end
        if (i_cmd.q_mul1) r_ratio_raw <= 40'(r_rd.life) * 40'(r_rd.rec);
        if (i_cmd.q_mul2) begin
            r_ph15 <= 35'(ratio) * 35'(ptu_pkg::K_PULSE15);
            r_ph20 <= 35'(ratio) * 35'(ptu_pkg::K_PULSE20);
            r_ar   <= 25'(r_rd.color[7:0]) * 25'(ratio);
        end
        if (i_cmd.q_mul3) begin
            r_alpha <= r_rd.sparkle ? arp[40:31] : {1'b0, r_ar[24:16]};
            r_half  <= r_rd.sparkle ? sg[28:12] : 17'({r_rd.size, 3'b000});
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_wr)  r_count <= r_count + 1'b1;
            if (i_cmd.cnt_dec) r_count <= cnt_m1;
            if (i_cmd.idx_clr) r_idx <= '0;
            if (i_cmd.upd_wr || i_cmd.q_out) r_idx <= r_idx + 1'b1;
            if (i_cmd.resp || i_cmd.q_out) r_out_valid <= 1'b1;
            else if (i_out_ready)          r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_out_kind <= r_drop ? ptu_pkg::KIND_DROP : ptu_pkg::KIND_ACCEPT;
            r_out_data <= '0;
            r_out_last <= 1'b1;
        end
        if (i_cmd.q_out) begin
            r_out_kind <= ptu_pkg::KIND_QUAD;
            r_out_data <= {r_rd.color[31:8], alpha_c,
                           ptu_pkg::sat24(26'(r_rd.pos_y) + hx),
                           ptu_pkg::sat24(26'(r_rd.pos_x) + hx),
                           ptu_pkg::sat24(26'(r_rd.pos_y) - hx),
                           ptu_pkg::sat24(26'(r_rd.pos_x) - hx)};
            r_out_last <= o_stat.idx_is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ptu_pkg::CNT_W'(ptu_pkg::SLOTS))
        else $error("particle count above table size");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("walk index beyond particle count");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
        ((r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1)))
        else $error("particle count moved by more than one");
`endif

endmodule

[hdl/particle_table_update_and_quads_core.sv]
// Particle table core: insert, tick update and quad output.
// Insert: the result beat follows the reciprocal divide, store write and response; a
// dropped insert skips the divide and write. Tick: the drag factor is stepped first, then
// each survivor is read, checked and rewritten, each expiry is read, checked and replaced
// by the last entry (dropped when it is the last one), a final read closes the walk, then
// each quad beat is read, multiplied and sent, waiting while output stalls; one item in
// flight at a time. Reset (i_rst_n low, synchronous) empties the table and output; store contents stay.
module particle_table_update_and_quads_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input beats
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // tdata from bit 0: step_time[12], pos_x[24], pos_y[24], vel_x[20], vel_y[20],
    // life[16], color[32], size[12], sparkle[1], zero pad[7]
    input  logic [ptu_pkg::IN_W-1:0]  i_s_tdata,
    // tuser: func (0 insert, 1 tick)
    input  logic                      i_s_tuser,
    // result beats
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // tdata from bit 0: left[24], top[24], right[24], bottom[24], quad_color[32]
    output logic [ptu_pkg::OUT_W-1:0] o_m_tdata,
    // tuser: kind (0 accepted, 1 dropped, 2 quad)
    output logic [1:0]                o_m_tuser,
    output logic                      o_m_tlast
);

    ptu_pkg::t_cmd  cmd;
    ptu_pkg::t_stat stat;

    // sequencer: decides each cycle's datapath action
    ptu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_stat     (stat),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    // datapath: particle store, divider, multipliers and output register
    ptu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_func      (i_s_tuser),
        .i_data      (i_s_tdata),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_kind  (o_m_tuser),
        .o_out_data  (o_m_tdata),
        .o_out_last  (o_m_tlast)
    );

endmodule
